>>> rtl/cft_pkg.sv
package cft_pkg;

	localparam int YEAR_W   = 15;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MIN_W    = 6;
	localparam int SEC_W    = 6;
	localparam int MS_W     = 10;
	localparam int TICKS_W  = 64;

	localparam int Y4_W     = YEAR_W - 2;
	localparam int Q25_W    = 9;
	localparam int DAYN_W   = 10;
	localparam int HMS_W    = 17;
	localparam int DAYS_W   = 26;
	localparam int T_W      = 44;
	localparam int SECS_W   = 42;
	localparam int SPLIT    = 20;
	localparam int PLO_W    = SPLIT + 24;
	localparam int PHI_W    = SECS_W - SPLIT + 24;

	localparam logic [YEAR_W-1:0]  YEAR_BASE   = 15'd1970;
	localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;
	localparam logic [SEC_W-1:0]   SEC_LEAP    = 6'd60;

	localparam logic [13:0]        RECIP25     = 14'd10486;
	localparam int                 RECIP_SHIFT = 18;
	localparam logic [DAYS_W-1:0]  LEAP_BIAS   = 26'd478;

	localparam logic [16:0]        SEC_PER_DAY = 17'd86400;
	localparam logic [23:0]        TICKS_SEC   = 24'd10000000;
	localparam logic [13:0]        TICKS_MS    = 14'd10000;
	localparam logic [TICKS_W-1:0] OFFSET_TICKS = 64'd116444736000000000;

	localparam logic [8:0] DAYS_BEFORE [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	typedef struct packed {
		logic s1;
		logic s2;
	} cft_adv_t;

endpackage

>>> rtl/cft_if.sv
interface cft_cal_if;
	logic        valid;
	logic        ready;
	logic [14:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic [9:0]  millisecond;

	modport source (output valid, year, month, day, hour, minute, second, millisecond,
		input ready);
	modport sink (input valid, year, month, day, hour, minute, second, millisecond,
		output ready);
endinterface

interface cft_ft_if;
	logic        valid;
	logic        ready;
	logic [63:0] ticks;
	logic        error;

	modport source (output valid, ticks, error, input ready);
	modport sink (input valid, ticks, error, output ready);
endinterface

>>> rtl/cft_days.sv
module cft_days import cft_pkg::*; (
	input  logic                     clk,
	input  cft_adv_t                 adv,
	input  logic [YEAR_W-1:0]        year,
	input  logic [MONTH_W-1:0]       month,
	input  logic [DAY_W-1:0]         day,
	input  logic [HOUR_W-1:0]        hour,
	input  logic [MIN_W-1:0]         minute,
	input  logic [SEC_W-1:0]         second,
	output logic signed [DAYS_W-1:0] days_s2,
	output logic [HMS_W-1:0]         hms_s2,
	output logic                     bad_s2
);

	localparam int PROD_W = Y4_W + 14;

	logic              bad_month;
	logic              early;
	logic [3:0]        mi;
	logic [YEAR_W-1:0] y;
	logic [Y4_W-1:0]   y4;
	logic [PROD_W-1:0] prod;
	logic [HMS_W-1:0]  hms;

	logic [Y4_W-1:0]   y4_s1;
	logic [Q25_W-1:0]  q25_s1;
	logic [YEAR_W-1:0] ybase_s1;
	logic [DAYN_W-1:0] dayn_s1;
	logic [HMS_W-1:0]  hms_s1;
	logic              bad_s1;

	always_comb begin
		bad_month = (month == '0) || (month > MONTH_DEC);
		early     = year < YEAR_BASE;
		mi        = bad_month ? 4'd0 : month - MONTH_JAN;
		y         = year - YEAR_W'((month == MONTH_JAN) || (month == MONTH_FEB));
		y4        = y[YEAR_W-1:2];
		prod      = PROD_W'(y4) * PROD_W'(RECIP25);
		hms       = HMS_W'(hour) * HMS_W'(3600) + HMS_W'(minute) * HMS_W'(60)
		          + HMS_W'(second) - HMS_W'(second >= SEC_LEAP);
	end

	// stage 1: year split, leap quotients, month offset, time of day
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			y4_s1    <= y4;
			q25_s1   <= prod[PROD_W-1:RECIP_SHIFT];
			ybase_s1 <= year - YEAR_BASE;
			dayn_s1  <= DAYN_W'(DAYS_BEFORE[mi]) + DAYN_W'(day);
			hms_s1   <= hms;
			bad_s1   <= bad_month || early;
		end
	end

	// stage 2: day count since 1970
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			days_s2 <= DAYS_W'(ybase_s1) * DAYS_W'(365) + DAYS_W'(dayn_s1) + DAYS_W'(y4_s1)
			         + DAYS_W'(q25_s1[Q25_W-1:2]) - DAYS_W'(q25_s1) - LEAP_BIAS;
			hms_s2  <= hms_s1;
			bad_s2  <= bad_s1;
		end
	end

endmodule

>>> rtl/calendar_to_filetime.sv
// calendar_to_filetime: utc calendar time to 100 ns ticks since 1601
// throughput: one beat per cycle while the output is not stalled, five-stage pipeline with per-stage valid bits
// a stalled output holds its stage and back-pressures only the stages behind it
// reset clears the valid bits only, payload registers are not reset
module calendar_to_filetime import cft_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	cft_cal_if.sink cal,
	cft_ft_if.source ft
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	cft_adv_t adv;

	logic signed [DAYS_W-1:0] days_s2;
	logic [HMS_W-1:0]         hms_s2;
	logic                     bad_s2;

	logic [MS_W-1:0] ms_s1, ms_s2, ms_s3;

	logic signed [T_W-1:0]    t;
	logic                     err;
	logic signed [SECS_W-1:0] secs_s3;
	logic                     err_s3;

	logic [SPLIT-1:0]                lo;
	logic signed [SECS_W-SPLIT-1:0]  hi;
	logic [PLO_W-1:0]                plo_s4;
	logic signed [PHI_W-1:0]         phi_s4;
	logic [TICKS_W-1:0]              msoff_s4;
	logic                            err_s4;

	logic [TICKS_W-1:0] ticks_s5;
	logic               err_s5;

	assign rdy5 = !v_s5 || ft.ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign adv  = '{s1: rdy1, s2: rdy2};

	assign cal.ready = rdy1;
	assign ft.valid  = v_s5;
	assign ft.ticks  = ticks_s5;
	assign ft.error  = err_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= cal.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	cft_days u_days (
		.clk     (clk),
		.adv     (adv),
		.year    (cal.year),
		.month   (cal.month),
		.day     (cal.day),
		.hour    (cal.hour),
		.minute  (cal.minute),
		.second  (cal.second),
		.days_s2 (days_s2),
		.hms_s2  (hms_s2),
		.bad_s2  (bad_s2)
	);

	always_ff @(posedge clk) begin
		if (rdy1) ms_s1 <= cal.millisecond;
		if (rdy2) ms_s2 <= ms_s1;
	end

	// stage 3: seconds since 1970, a negative count, bad month or year before 1970 forces -1
	always_comb begin
		t   = T_W'(days_s2) * $signed(T_W'(SEC_PER_DAY)) + $signed(T_W'(hms_s2));
		err = bad_s2 || t[T_W-1];
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			secs_s3 <= err ? '1 : t[SECS_W-1:0];
			err_s3  <= err;
			ms_s3   <= ms_s2;
		end
	end

	// stage 4: split scaling by 10^7, millisecond term plus epoch offset
	assign lo = secs_s3[SPLIT-1:0];
	assign hi = secs_s3[SECS_W-1:SPLIT];

	always_ff @(posedge clk) begin
		if (rdy4) begin
			plo_s4   <= PLO_W'(lo) * PLO_W'(TICKS_SEC);
			phi_s4   <= PHI_W'(hi) * $signed(PHI_W'(TICKS_SEC));
			msoff_s4 <= TICKS_W'(ms_s3) * TICKS_W'(TICKS_MS) + OFFSET_TICKS;
			err_s4   <= err_s3;
		end
	end

	// stage 5: recombine partial products and add the millisecond and offset term
	always_ff @(posedge clk) begin
		if (rdy5) begin
			ticks_s5 <= (TICKS_W'(phi_s4) << SPLIT) + TICKS_W'(plo_s4) + msoff_s4;
			err_s5   <= err_s4;
		end
	end

	a_err_secs: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && err_s3 |-> secs_s3 == '1)
		else $error("error beat without all-ones second count");

	a_ok_secs: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !err_s3 |-> !secs_s3[SECS_W-1])
		else $error("negative second count without error");

	a_bad_date: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && rdy3 && bad_s2 |=> v_s3 && err_s3)
		else $error("bad month or year lost its error flag");

	a_err_path: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && rdy5 |=> v_s5 && err_s5 == $past(err_s4))
		else $error("error flag changed between last stages");

endmodule
